[design/epsd_pkg.sv]
// shared types, constants and codes of the event publish/subscribe dispatcher
package epsd_pkg;

  localparam int HANDLERS    = 64;
  localparam int EVENT_TYPES = 64;
  localparam int USER_BASE   = 4;

  localparam int HandlerW = $clog2(HANDLERS);
  localparam int RowW     = (EVENT_TYPES > 1) ? $clog2(EVENT_TYPES) : 1;
  localparam int RowCntW  = $clog2(EVENT_TYPES + 1);

  localparam int CfgRowsW = 7;
  localparam int HidW     = 6;
  localparam int EvW      = 16;
  localparam int TagW     = 16;
  localparam int StW      = 3;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_SUBSCRIBE  = 3'd2,
    OP_UNSUB      = 3'd3,
    OP_UNSUB_ALL  = 3'd4,
    OP_POST       = 3'd5,
    OP_PUBLISH    = 3'd6
  } opcode_e;

  typedef enum logic [StW-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_HANDLER = 3'd1,
    ST_NOT_REG     = 3'd2,
    ST_BAD_EVENT   = 3'd3,
    ST_ALREADY_REG = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SUB_RD,
    S_PUB_RD,
    S_SCAN,
    S_CLR,
    S_RESP
  } state_e;

  typedef enum logic {
    REG_PUBSUB_EN = 1'b0,
    REG_TYPES_USE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic                enabled;
    logic [CfgRowsW-1:0] rows;
  } cfg_t;

  typedef struct packed {
    logic [HidW-1:0] excl;
    logic            excl_en;
    logic [TagW-1:0] tag;
    logic [EvW-1:0]  ev_code;
    logic [HidW-1:0] handler;
    opcode_e         op;
  } item_t;

  typedef struct packed {
    status_e         status;
    logic            last;
    logic [TagW-1:0] tag;
    logic [HidW-1:0] dest;
    logic            deliver;
  } res_t;

endpackage

[design/epsd_ram.sv]
// generic single write port ram with registered read
module epsd_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/epsd_ctrl.sv]
// operation sequencer: checks, bitmap row updates, handler scan and result register
module epsd_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  epsd_pkg::cfg_t                    cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  epsd_pkg::item_t                   in_item_i,
  output logic                              ram_we_o,
  output logic [epsd_pkg::RowW-1:0]         ram_waddr_o,
  output logic [epsd_pkg::HANDLERS-1:0]     ram_wdata_o,
  output logic [epsd_pkg::RowW-1:0]         ram_raddr_o,
  input  logic [epsd_pkg::HANDLERS-1:0]     ram_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output epsd_pkg::res_t                    out_res_o
);

  localparam int H = epsd_pkg::HANDLERS;
  localparam logic [H-1:0] One = {{(H-1){1'b0}}, 1'b1};

  epsd_pkg::state_e state_q, state_d;
  epsd_pkg::item_t  item_q, item_d;
  logic [H-1:0]     reg_mask_q, reg_mask_d;
  logic [epsd_pkg::EVENT_TYPES-1:0] row_valid_q, row_valid_d;
  logic             rvalid_q;
  logic [H-1:0]     pend_q, pend_d;
  logic [epsd_pkg::HandlerW-1:0] idx_q, idx_d;
  logic [epsd_pkg::RowCntW-1:0]  cnt_q, cnt_d;
  epsd_pkg::res_t   rsp_q, rsp_d;
  logic             out_valid_q, out_valid_d;
  epsd_pkg::res_t   out_res_q, out_res_d;

  logic [epsd_pkg::HandlerW-1:0] h_idx;
  logic [H-1:0]     h_bit;
  logic [H-1:0]     excl_bit;
  logic             h_bad;
  logic             is_reg;
  logic             ev_low;
  logic [epsd_pkg::EvW-1:0]     row_full;
  logic [epsd_pkg::RowCntW-1:0] rows_use;
  logic             row_ok;
  logic [epsd_pkg::RowW-1:0]    row_idx;
  logic [H-1:0]     row_data;
  logic [H-1:0]     pend_rest;
  logic             slot_free;
  logic             push;
  epsd_pkg::res_t   push_res;
  logic [epsd_pkg::RowCntW-1:0] cnt_nxt;

  assign h_idx    = item_q.handler[epsd_pkg::HandlerW-1:0];
  assign h_bit    = One << h_idx;
  assign h_bad    = {1'b0, item_q.handler} >= (epsd_pkg::HidW+1)'(H);
  assign is_reg   = reg_mask_q[h_idx];
  // an excluded handler out of range excludes nothing
  assign excl_bit = (item_q.excl_en && ({1'b0, item_q.excl} < (epsd_pkg::HidW+1)'(H))) ?
                    (One << item_q.excl[epsd_pkg::HandlerW-1:0]) : '0;
  assign ev_low   = item_q.ev_code < epsd_pkg::EvW'(epsd_pkg::USER_BASE);
  assign row_full = item_q.ev_code - epsd_pkg::EvW'(epsd_pkg::USER_BASE);
  assign rows_use = (epsd_pkg::EvW'(cfg_i.rows) > epsd_pkg::EvW'(epsd_pkg::EVENT_TYPES)) ?
                    epsd_pkg::RowCntW'(epsd_pkg::EVENT_TYPES) :
                    epsd_pkg::RowCntW'(cfg_i.rows);
  assign row_ok   = !ev_low && cfg_i.enabled &&
                    (row_full < epsd_pkg::EvW'(rows_use));
  assign row_idx  = row_full[epsd_pkg::RowW-1:0];
  // rows never written read as zero
  assign row_data = ram_rdata_i & {H{rvalid_q}};
  assign pend_rest = pend_q & ~(One << idx_q);
  assign slot_free = !out_valid_q || out_ready_i;
  assign cnt_nxt   = cnt_q + epsd_pkg::RowCntW'(1);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    reg_mask_d  = reg_mask_q;
    row_valid_d = row_valid_q;
    pend_d      = pend_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    rsp_d       = rsp_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = row_idx;
    ram_wdata_o = row_data;
    ram_raddr_o = row_idx;
    push        = 1'b0;
    push_res    = rsp_q;
    in_ready_o  = (state_q == epsd_pkg::S_IDLE);

    case (state_q)
      epsd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = epsd_pkg::S_DECODE;
        end
      end

      epsd_pkg::S_DECODE: begin
        rsp_d.deliver = 1'b0;
        rsp_d.dest    = '0;
        rsp_d.tag     = item_q.tag;
        rsp_d.last    = 1'b1;
        rsp_d.status  = epsd_pkg::ST_OK;
        state_d       = epsd_pkg::S_RESP;
        if (item_q.op == epsd_pkg::OP_PUBLISH) begin
          if (!row_ok) begin
            rsp_d.status = epsd_pkg::ST_BAD_EVENT;
          end else begin
            state_d = epsd_pkg::S_PUB_RD;
          end
        end else if (h_bad) begin
          rsp_d.status = epsd_pkg::ST_BAD_HANDLER;
        end else begin
          case (item_q.op)
            epsd_pkg::OP_REGISTER: begin
              if (is_reg) begin
                rsp_d.status = epsd_pkg::ST_ALREADY_REG;
              end else begin
                reg_mask_d = reg_mask_q | h_bit;
              end
            end
            epsd_pkg::OP_UNREGISTER, epsd_pkg::OP_UNSUB_ALL: begin
              ram_raddr_o = '0;
              cnt_d       = '0;
              if (!is_reg) begin
                rsp_d.status = epsd_pkg::ST_NOT_REG;
              end else if (rows_use == '0) begin
                if (item_q.op == epsd_pkg::OP_UNREGISTER) begin
                  reg_mask_d = reg_mask_q & ~h_bit;
                end
              end else begin
                state_d = epsd_pkg::S_CLR;
              end
            end
            epsd_pkg::OP_SUBSCRIBE, epsd_pkg::OP_UNSUB: begin
              if (!is_reg) begin
                rsp_d.status = epsd_pkg::ST_NOT_REG;
              end else if (!row_ok) begin
                rsp_d.status = epsd_pkg::ST_BAD_EVENT;
              end else begin
                state_d = epsd_pkg::S_SUB_RD;
              end
            end
            epsd_pkg::OP_POST: begin
              if (ev_low) begin
                rsp_d.status = epsd_pkg::ST_BAD_EVENT;
              end else if (!is_reg) begin
                rsp_d.status = epsd_pkg::ST_NOT_REG;
              end else begin
                rsp_d.deliver = 1'b1;
                rsp_d.dest    = item_q.handler;
              end
            end
            default: begin
              // unused opcode gives no result
              state_d = epsd_pkg::S_IDLE;
            end
          endcase
        end
      end

      epsd_pkg::S_SUB_RD: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = (item_q.op == epsd_pkg::OP_SUBSCRIBE) ? (row_data | h_bit) :
                                                              (row_data & ~h_bit);
        row_valid_d[row_idx] = 1'b1;
        state_d = epsd_pkg::S_RESP;
      end

      epsd_pkg::S_CLR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q[epsd_pkg::RowW-1:0];
        ram_wdata_o = row_data & ~h_bit;
        row_valid_d[cnt_q[epsd_pkg::RowW-1:0]] = 1'b1;
        ram_raddr_o = cnt_nxt[epsd_pkg::RowW-1:0];
        cnt_d       = cnt_nxt;
        if (cnt_nxt == rows_use) begin
          if (item_q.op == epsd_pkg::OP_UNREGISTER) begin
            reg_mask_d = reg_mask_q & ~h_bit;
          end
          state_d = epsd_pkg::S_RESP;
        end
      end

      epsd_pkg::S_PUB_RD: begin
        pend_d = row_data & reg_mask_q & ~excl_bit;
        idx_d  = epsd_pkg::HandlerW'(H - 1);
        if ((row_data & reg_mask_q & ~excl_bit) == '0) begin
          state_d = epsd_pkg::S_RESP;
        end else begin
          state_d = epsd_pkg::S_SCAN;
        end
      end

      epsd_pkg::S_SCAN: begin
        // one handler bit per cycle unless a delivery is held, highest first
        if (pend_q[idx_q]) begin
          if (slot_free) begin
            push             = 1'b1;
            push_res.deliver = 1'b1;
            push_res.dest    = epsd_pkg::HidW'(idx_q);
            push_res.last    = (pend_rest == '0);
            push_res.status  = epsd_pkg::ST_OK;
            pend_d           = pend_rest;
            if (pend_rest == '0) begin
              state_d = epsd_pkg::S_IDLE;
            end else begin
              idx_d = idx_q - epsd_pkg::HandlerW'(1);
            end
          end
        end else begin
          idx_d = idx_q - epsd_pkg::HandlerW'(1);
        end
      end

      epsd_pkg::S_RESP: begin
        if (slot_free) begin
          push    = 1'b1;
          state_d = epsd_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = epsd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_res_d   = push_res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= epsd_pkg::S_IDLE;
      reg_mask_q  <= '0;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      reg_mask_q  <= reg_mask_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    pend_q    <= pend_d;
    idx_q     <= idx_d;
    cnt_q     <= cnt_d;
    rsp_q     <= rsp_d;
    out_res_q <= out_res_d;
    rvalid_q  <= row_valid_q[ram_raddr_o];
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

[design/event_pubsub_dispatcher_unit.sv]
// Event publish/subscribe dispatcher top level: stream ports, register port, bitmap ram.
// Requests enter on the s_axis channel (tuser = opcode) and results leave on m_axis,
// with tlast on the final result of each request. Registers: pubsub_enabled at 0x0,
// event_types_in_use at 0x4, written through the APB port; the user must write them
// only while idle, the block does not enforce it. One request at a time: s_axis_tready
// is high only while the sequencer is idle. Register, post and failed checks go from
// decode straight to the result; subscribe and unsubscribe read and rewrite their row;
// unregister and unsubscribe-all walk each bitmap row in use, one ram read and write a
// cycle. Publish reads the row, then scans one handler bit per cycle from the top,
// each delivery leaving as its bit is reached. A single result register parts the
// two sides: the next request is taken while the last result still waits. When that
// register is full and m_axis_tready is low the scan holds at the pending handler and
// nothing is lost. Reset clears the handler mask, the row valid bits (rows never
// written read as zero, so no clearing pass) and both registers.
module event_pubsub_dispatcher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request: handler, event type, event tag, exclude enable, excluded handler
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // opcode
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // dest_handler, out_event_tag, status
  output logic [31:0] m_axis_tdata,
  // deliver
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                              en_q, en_d;
  logic [epsd_pkg::CfgRowsW-1:0]     rows_q, rows_d;
  epsd_pkg::cfg_t                    cfg;
  epsd_pkg::item_t                   item;
  epsd_pkg::res_t                    res;
  epsd_pkg::reg_idx_e                reg_sel;
  logic                              ram_we;
  logic [epsd_pkg::RowW-1:0]         ram_waddr;
  logic [epsd_pkg::HANDLERS-1:0]     ram_wdata;
  logic [epsd_pkg::RowW-1:0]         ram_raddr;
  logic [epsd_pkg::HANDLERS-1:0]     ram_rdata;

  assign pready  = 1'b1;
  assign reg_sel = epsd_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    en_d   = en_q;
    rows_d = rows_q;
    if (psel && penable && pwrite) begin
      case (reg_sel)
        epsd_pkg::REG_PUBSUB_EN: en_d   = pwdata[0];
        epsd_pkg::REG_TYPES_USE: rows_d = pwdata[epsd_pkg::CfgRowsW-1:0];
        default:                 en_d   = en_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      epsd_pkg::REG_PUBSUB_EN: prdata = {31'd0, en_q};
      epsd_pkg::REG_TYPES_USE: prdata = {{(32-epsd_pkg::CfgRowsW){1'b0}}, rows_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      rows_q <= '0;
    end else begin
      en_q   <= en_d;
      rows_q <= rows_d;
    end
  end

  assign cfg.enabled = en_q;
  assign cfg.rows    = rows_q;

  assign item.op       = epsd_pkg::opcode_e'(s_axis_tuser);
  assign item.handler  = s_axis_tdata[5:0];
  assign item.ev_code  = s_axis_tdata[21:6];
  assign item.tag      = s_axis_tdata[37:22];
  assign item.excl_en  = s_axis_tdata[38];
  assign item.excl     = s_axis_tdata[44:39];

  epsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  epsd_ram #(
    .Width (epsd_pkg::HANDLERS),
    .Depth (epsd_pkg::EVENT_TYPES)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tdata = {7'd0, res.status, res.tag, res.dest};
  assign m_axis_tuser = res.deliver;
  assign m_axis_tlast = res.last;

endmodule

[tb/sv/event_pubsub_dispatcher_unit_test.sv]
`timescale 1ns / 1ps
// self-checking testbench of the event publish/subscribe dispatcher unit
module event_pubsub_dispatcher_unit_test;
  import epsd_pkg::*;

  localparam logic [2:0] OP_UNUSED     = 3'd7;
  localparam int         IDLE_LIMIT    = 5000;
  localparam int         SETTLE_CYCLES = 80;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         PHASE_ITEMS   = 31;
  localparam int         PHASES        = 8;

  // mirror of the routing tables plus the queue of results still owed
  class delivery_tracker;
    logic [HANDLERS-1:0] sub_rows [EVENT_TYPES];
    logic [HANDLERS-1:0] reg_mask;
    logic                enabled;
    logic [CfgRowsW-1:0] rows_cfg;
    res_t                due_results[$];
    int                  errors;

    function new();
      foreach (sub_rows[i]) sub_rows[i] = '0;
      reg_mask = '0;
      enabled  = 1'b0;
      rows_cfg = '0;
      errors   = 0;
    endfunction

    function int rows_live();
      return (rows_cfg > EVENT_TYPES) ? EVENT_TYPES : int'(rows_cfg);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void set_config(reg_idx_e idx, logic [31:0] value);
      if (idx == REG_PUBSUB_EN) begin
        enabled = value[0];
      end else begin
        rows_cfg = value[CfgRowsW-1:0];
      end
    endfunction

    function status_e event_status(logic [EvW-1:0] ev, bit need_table, output int row);
      row = int'(ev) - USER_BASE;
      if (int'(ev) < USER_BASE) return ST_BAD_EVENT;
      if (need_table && (!enabled || row >= rows_live())) return ST_BAD_EVENT;
      return ST_OK;
    endfunction

    function void push(logic dlv, logic [HidW-1:0] dest, logic [TagW-1:0] tag,
                       logic last, status_e st);
      res_t r;
      r.deliver = dlv;
      r.dest    = dest;
      r.tag     = tag;
      r.last    = last;
      r.status  = st;
      due_results.push_back(r);
    endfunction

    function void note_request(item_t rq);
      logic [HANDLERS-1:0] hit;
      int                  row;
      int                  left;
      status_e             st;
      logic                known;
      if (rq.op == OP_UNUSED) return;
      if (rq.op == OP_PUBLISH) begin
        st = event_status(rq.ev_code, 1'b1, row);
        if (st != ST_OK) begin
          push(1'b0, '0, rq.tag, 1'b1, st);
          return;
        end
        hit = sub_rows[row] & reg_mask;
        if (rq.excl_en && rq.excl < HANDLERS) hit[rq.excl] = 1'b0;
        left = $countones(hit);
        if (left == 0) push(1'b0, '0, rq.tag, 1'b1, ST_OK);
        // highest handler first, tlast on the final delivery
        for (int i = HANDLERS - 1; i >= 0; i--) begin
          if (hit[i]) begin
            left--;
            push(1'b1, HidW'(i), rq.tag, left == 0, ST_OK);
          end
        end
        return;
      end
      if (rq.handler >= HANDLERS) begin
        push(1'b0, '0, rq.tag, 1'b1, ST_BAD_HANDLER);
        return;
      end
      known = reg_mask[rq.handler];
      st    = ST_OK;
      case (rq.op)
        OP_REGISTER: begin
          if (known) st = ST_ALREADY_REG;
          else reg_mask[rq.handler] = 1'b1;
        end
        OP_UNREGISTER, OP_UNSUB_ALL: begin
          if (!known) begin
            st = ST_NOT_REG;
          end else begin
            // only rows in use get cleared, the rest keep their bits
            for (int i = 0; i < rows_live(); i++) sub_rows[i][rq.handler] = 1'b0;
            if (rq.op == OP_UNREGISTER) reg_mask[rq.handler] = 1'b0;
          end
        end
        OP_SUBSCRIBE, OP_UNSUB: begin
          if (!known) begin
            st = ST_NOT_REG;
          end else begin
            st = event_status(rq.ev_code, 1'b1, row);
            if (st == ST_OK) sub_rows[row][rq.handler] = (rq.op == OP_SUBSCRIBE);
          end
        end
        default: begin
          // post skips the table checks
          st = event_status(rq.ev_code, 1'b0, row);
          if (st == ST_OK && !known) st = ST_NOT_REG;
          if (st == ST_OK) begin
            push(1'b1, rq.handler, rq.tag, 1'b1, ST_OK);
            return;
          end
        end
      endcase
      push(1'b0, '0, rq.tag, 1'b1, st);
    endfunction

    function void mismatch(string field, int want, int got);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %0b/%0d/%h/%0b/%0d",
                 $time, got.deliver, got.dest, got.tag, got.last, got.status);
        return;
      end
      want = due_results.pop_front();
      if (got.deliver !== want.deliver) mismatch("deliver", want.deliver, got.deliver);
      if (got.dest !== want.dest) mismatch("dest_handler", want.dest, got.dest);
      if (got.tag !== want.tag) mismatch("event_tag", want.tag, got.tag);
      if (got.last !== want.last) mismatch("last", want.last, got.last);
      if (got.status !== want.status) mismatch("status", want.status, got.status);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  delivery_tracker sb = new();
  int              burst_left = 0;
  bit              sink_hold_ask = 1'b0;

  event_pubsub_dispatcher_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic item_t make_request(logic [2:0] op, logic [HidW-1:0] h,
                                         logic [EvW-1:0] ev, logic [TagW-1:0] tag,
                                         logic xen, logic [HidW-1:0] x);
    item_t rq;
    rq.op       = opcode_e'(op);
    rq.handler  = h;
    rq.ev_code  = ev;
    rq.tag      = tag;
    rq.excl_en  = xen;
    rq.excl     = x;
    return rq;
  endfunction

  // mostly well-formed traffic on a few busy rows and handlers, some noise
  function automatic item_t rand_request();
    int              pick;
    int              live;
    logic [2:0]      op;
    logic [HidW-1:0] h;
    logic [HidW-1:0] x;
    logic [EvW-1:0]  ev;
    pick = $urandom_range(0, 99);
    if (pick < 20) op = OP_REGISTER;
    else if (pick < 25) op = OP_UNREGISTER;
    else if (pick < 50) op = OP_SUBSCRIBE;
    else if (pick < 57) op = OP_UNSUB;
    else if (pick < 60) op = OP_UNSUB_ALL;
    else if (pick < 70) op = OP_POST;
    else if (pick < 97) op = OP_PUBLISH;
    else op = OP_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick < 5) h = HidW'($urandom_range(0, 7));
    else if (pick < 7) h = HidW'($urandom_range(56, 63));
    else h = HidW'($urandom_range(0, 63));
    x = ($urandom_range(0, 1) == 0) ? HidW'($urandom_range(0, 7)) : HidW'($urandom_range(0, 63));
    live = sb.rows_live();
    pick = $urandom_range(0, 99);
    if (pick < 55) ev = EvW'(USER_BASE + $urandom_range(0, (live < 4) ? live : 3));
    else if (pick < 85) ev = EvW'(USER_BASE + $urandom_range(0, live + 1));
    else if (pick < 92) ev = EvW'($urandom_range(0, USER_BASE - 1));
    else ev = EvW'($urandom_range(0, 16'hFFFF));
    return make_request(op, h, ev, TagW'($urandom_range(0, 16'hFFFF)),
                        $urandom_range(0, 2) == 0, x);
  endfunction

  // offer one request in bursts with random gaps, return at its acceptance edge
  task automatic send_request(input item_t rq);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, rq.excl, rq.excl_en, rq.tag, rq.ev_code, rq.handler};
    s_axis_tuser  <= rq.op;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_request(rq);
  endtask

  // stop offering and let every owed result and any silent work finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_config(idx, value);
    @(posedge clk_i);
  endtask

  // result side: check accepted results, stall on a changing pattern
  initial begin : result_sink
    int   mode;
    int   mode_left;
    int   off_left;
    int   hold_left;
    res_t got;
    mode          = 0;
    mode_left     = 0;
    off_left      = 0;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.dest    = m_axis_tdata[5:0];
        got.tag     = m_axis_tdata[21:6];
        got.status  = status_e'(m_axis_tdata[24:22]);
        got.deliver = m_axis_tuser;
        got.last    = m_axis_tlast;
        sb.check_result(got);
      end
      if (sink_hold_ask) begin
        sink_hold_ask = 1'b0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            if (off_left > 0) begin
              off_left--;
              m_axis_tready <= 1'b0;
            end else begin
              m_axis_tready <= 1'b1;
              if ($urandom_range(0, 7) == 0) off_left = $urandom_range(1, 15);
            end
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int         n;
    item_t      rq;
    logic       phase_en   [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    logic [6:0] phase_rows [PHASES] = '{7'd64, 7'd5, 7'd0, 7'd127, 7'd1, 7'd64, 7'd0, 7'd64};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tables detached: of the requests sent here only register and post can succeed
    send_request(make_request(OP_REGISTER, 6'd0, 16'd0, 16'h0000, 1'b0, 6'd0));
    send_request(make_request(OP_REGISTER, 6'd0, 16'd0, 16'h0001, 1'b0, 6'd0));
    send_request(make_request(OP_SUBSCRIBE, 6'd0, USER_BASE, 16'h0002, 1'b0, 6'd0));
    send_request(make_request(OP_POST, 6'd0, USER_BASE, 16'h0003, 1'b0, 6'd0));
    send_request(make_request(OP_POST, 6'd63, 16'hFFFF, 16'h0004, 1'b0, 6'd0));
    send_request(make_request(OP_POST, 6'd0, 16'd0, 16'h0005, 1'b0, 6'd0));
    send_request(make_request(OP_PUBLISH, 6'd0, USER_BASE, 16'h0006, 1'b0, 6'd0));
    send_request(make_request(OP_UNUSED, 6'd63, 16'hFFFF, 16'hFFFF, 1'b1, 6'd63));
    drain();
    write_reg(REG_PUBSUB_EN, 32'd1);
    write_reg(REG_TYPES_USE, 32'd64);

    send_request(make_request(OP_REGISTER, 6'd63, 16'd0, 16'h0010, 1'b0, 6'd0));
    send_request(make_request(OP_REGISTER, 6'd62, 16'd0, 16'h0011, 1'b0, 6'd0));
    send_request(make_request(OP_SUBSCRIBE, 6'd0, USER_BASE, 16'h0012, 1'b0, 6'd0));
    send_request(make_request(OP_SUBSCRIBE, 6'd63, USER_BASE, 16'h0013, 1'b0, 6'd0));
    send_request(make_request(OP_SUBSCRIBE, 6'd62, USER_BASE, 16'h0014, 1'b0, 6'd0));
    send_request(make_request(OP_SUBSCRIBE, 6'd63, USER_BASE + 63, 16'h0015, 1'b0, 6'd0));
    send_request(make_request(OP_SUBSCRIBE, 6'd63, USER_BASE + 64, 16'h0016, 1'b0, 6'd0));
    // registration is checked before the event
    send_request(make_request(OP_SUBSCRIBE, 6'd5, 16'd0, 16'h0017, 1'b0, 6'd0));
    send_request(make_request(OP_PUBLISH, 6'd0, USER_BASE, 16'hFFFF, 1'b0, 6'd63));
    send_request(make_request(OP_PUBLISH, 6'd0, USER_BASE, 16'h0018, 1'b1, 6'd62));
    send_request(make_request(OP_UNSUB, 6'd62, USER_BASE, 16'h0019, 1'b0, 6'd0));
    send_request(make_request(OP_PUBLISH, 6'd63, USER_BASE, 16'h001A, 1'b1, 6'd5));
    send_request(make_request(OP_UNSUB_ALL, 6'd0, 16'd0, 16'h001B, 1'b0, 6'd0));
    send_request(make_request(OP_UNSUB_ALL, 6'd10, 16'd0, 16'h001C, 1'b0, 6'd0));
    send_request(make_request(OP_UNREGISTER, 6'd63, 16'd0, 16'h001D, 1'b0, 6'd0));
    send_request(make_request(OP_PUBLISH, 6'd0, USER_BASE + 63, 16'h001E, 1'b0, 6'd0));
    send_request(make_request(OP_UNREGISTER, 6'd63, 16'd0, 16'h001F, 1'b0, 6'd0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_PUBSUB_EN, {31'd0, phase_en[p]});
      write_reg(REG_TYPES_USE, {25'd0, phase_rows[p]});
      n = 0;
      while (n < PHASE_ITEMS) begin
        rq = rand_request();
        // long result stall while requests keep coming
        if (p == 0 && n == 12) sink_hold_ask = 1'b1;
        send_request(rq);
        if (rq.op != OP_UNUSED) n++;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
